### sv/alwf_pkg.sv
package alwf_pkg;

  // Ring geometry. Widths below follow from the depth.
  localparam int RING_DEPTH = 8;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);

  // Width of the queue occupancy fields on the result channel.
  localparam int QUEUED_W = 4;

  // Fixed command prefix sent before every word: "AT+CIPSEND=0,2" CR LF.
  localparam int PREFIX_LEN   = 16;
  localparam int PREFIX_IDX_W = 4;
  localparam int PREFIX_POS_W = 5;

  // Receive framing.
  localparam int SKIP_COUNT = 6;
  localparam int SKIP_W     = 3;
  localparam int LEN_W      = 4;
  localparam int MAX_LEN    = 8;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;
  typedef logic [RING_AW-1:0]      ring_ptr_t;
  typedef logic [FILL_W-1:0]       fill_t;
  typedef logic [QUEUED_W-1:0]     queued_t;
  typedef logic [PREFIX_POS_W-1:0] prefix_pos_t;
  typedef logic [SKIP_W-1:0]       skip_t;
  typedef logic [LEN_W-1:0]        len_t;

  typedef enum logic [1:0] {
    CMD_RX_BYTE = 2'd0,
    CMD_TX_TICK = 2'd1,
    CMD_ENQUEUE = 2'd2,
    CMD_DEQUEUE = 2'd3
  } cmd_t;

  localparam byte_t CHAR_PLUS   = 8'h2B;
  localparam byte_t CHAR_PROMPT = 8'h3E;
  localparam byte_t DIGIT_ZERO  = 8'h30;

  localparam byte_t PREFIX_TEXT [PREFIX_LEN] = '{
    8'h41, 8'h54, 8'h2B, 8'h43, 8'h49, 8'h50, 8'h53, 8'h45,
    8'h4E, 8'h44, 8'h3D, 8'h30, 8'h2C, 8'h32, 8'h0D, 8'h0A
  };

  // What the receive parser reports for one received byte.
  typedef struct packed {
    logic  word_push;
    word_t word;
    logic  permit_set;
  } rxp_evt_t;

  // One result transaction.
  typedef struct packed {
    logic    tx_valid;
    byte_t   tx_byte;
    logic    tx_idle;
    word_t   rx_word;
    logic    rx_word_valid;
    queued_t rx_queued;
    queued_t tx_queued;
    logic    send_permitted;
  } result_t;

  // Index of the oldest entry of a ring, given its write pointer and fill.
  function automatic ring_ptr_t ring_oldest(ring_ptr_t wpos, fill_t fill);
    logic [FILL_W:0] sum;
    sum = (FILL_W+1)'(wpos) + (FILL_W+1)'(RING_DEPTH) - (FILL_W+1)'(fill);
    if (sum >= (FILL_W+1)'(RING_DEPTH)) begin
      sum = sum - (FILL_W+1)'(RING_DEPTH);
    end
    return sum[RING_AW-1:0];
  endfunction

  function automatic ring_ptr_t ring_next(ring_ptr_t wpos);
    ring_ptr_t nxt;
    if (wpos == RING_AW'(RING_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = wpos + 1'b1;
    end
    return nxt;
  endfunction

endpackage

### sv/alwf_if.sv
interface alwf_in_if import alwf_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  command;
  byte_t rx_byte;
  word_t send_word;

  modport source (output valid, command, rx_byte, send_word, input ready);
  modport sink   (input valid, command, rx_byte, send_word, output ready);
endinterface

interface alwf_out_if import alwf_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    tx_valid;
  byte_t   tx_byte;
  logic    tx_idle;
  word_t   rx_word;
  logic    rx_word_valid;
  queued_t rx_queued;
  queued_t tx_queued;
  logic    send_permitted;

  modport source (output valid, tx_valid, tx_byte, tx_idle, rx_word, rx_word_valid,
                  rx_queued, tx_queued, send_permitted, input ready);
  modport sink   (input valid, tx_valid, tx_byte, tx_idle, rx_word, rx_word_valid,
                  rx_queued, tx_queued, send_permitted, output ready);
endinterface

### sv/alwf_rx_parser.sv
module alwf_rx_parser import alwf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     byte_en,
  input  byte_t    rx_byte,
  output rxp_evt_t evt
);

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_SKIP = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_GAP  = 6'b001000,
    PH_HIGH = 6'b010000,
    PH_LOW  = 6'b100000
  } phase_t;

  phase_t phase_r, phase_nxt;
  skip_t  skip_r, skip_nxt;
  len_t   left_r, left_nxt;
  byte_t  high_r, high_nxt;
  byte_t  digit;

  always_comb begin
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    left_nxt  = left_r;
    high_nxt  = high_r;
    evt       = '0;
    digit     = rx_byte - DIGIT_ZERO;
    if (byte_en) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (rx_byte == CHAR_PLUS) begin
            skip_nxt  = SKIP_W'(SKIP_COUNT);
            phase_nxt = PH_SKIP;
          end else if (rx_byte == CHAR_PROMPT) begin
            evt.permit_set = 1'b1;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_r - 1'b1;
          if (skip_nxt == '0) begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          priority if (rx_byte < DIGIT_ZERO) begin
            left_nxt = '0;
          end else if (digit > byte_t'(MAX_LEN)) begin
            left_nxt = LEN_W'(MAX_LEN);
          end else begin
            left_nxt = digit[LEN_W-1:0];
          end
          phase_nxt = PH_GAP;
        end
        PH_GAP: begin
          phase_nxt = PH_HIGH;
        end
        PH_HIGH: begin
          high_nxt  = rx_byte;
          phase_nxt = PH_LOW;
        end
        PH_LOW: begin
          evt.word_push = 1'b1;
          evt.word      = {high_r, rx_byte};
          if (left_r <= LEN_W'(2)) begin
            left_nxt  = '0;
            phase_nxt = PH_IDLE;
          end else begin
            left_nxt  = left_r - LEN_W'(2);
            phase_nxt = PH_HIGH;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      skip_r  <= '0;
      left_r  <= '0;
      high_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      left_r  <= left_nxt;
      high_r  <= high_nxt;
    end
  end

endmodule

### sv/at_link_word_framer.sv
// Word framer for a byte link to a text-command modem. Every input transaction
// carries one command: a byte received from the modem, a transmitter-ready
// tick, a 16-bit word to queue for sending, or a request to dequeue a received
// word. Every input transaction yields exactly one result transaction, in
// order, holding the byte to transmit (if any), the dequeued word (if any),
// the occupancy of both eight-word rings after the command and the send
// permit. Received frames start at '+', skip six bytes, take one ASCII length
// digit (clamped to 0..8), skip one more byte and then pack high/low byte
// pairs into the receive ring; a '>' outside a frame grants the send permit.
// Each ready tick with words queued sends one byte of the fixed prefix
// "AT+CIPSEND=0,2" CR LF; once the prefix is out and the permit is held, the
// oldest queued word goes out low byte first, after which it is removed, the
// permit is dropped and the prefix starts again. Both rings overwrite their
// oldest word when full. Throughput is one transaction per clock while input
// ready is high: all the work for a command is done in a single pass between
// the state registers and the result register (or the skid register while
// the port is stalled). A two-entry result buffer (result register plus skid
// register) lets the block keep accepting input while one result waits to be
// taken; input ready drops only while both entries are occupied. There is no
// clearing pass after reset: the block is ready as soon as reset is released.
module at_link_word_framer import alwf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  alwf_in_if.sink    in_item,
  alwf_out_if.source out_item
);

  // Receive parser.
  rxp_evt_t evt;
  logic     in_acc;
  logic     byte_en;

  assign in_acc  = in_item.valid && in_item.ready;
  assign byte_en = in_acc && (in_item.command == CMD_RX_BYTE);

  alwf_rx_parser u_rx_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (byte_en),
    .rx_byte (in_item.rx_byte),
    .evt     (evt)
  );

  // Ring storage. Entries are only read inside the filled span, so they need
  // no reset.
  word_t rx_ring_r [RING_DEPTH];
  word_t tx_ring_r [RING_DEPTH];

  ring_ptr_t   rx_wpos_r, rx_wpos_nxt;
  fill_t       rx_fill_r, rx_fill_nxt;
  ring_ptr_t   tx_wpos_r, tx_wpos_nxt;
  fill_t       tx_fill_r, tx_fill_nxt;
  prefix_pos_t prefix_pos_r, prefix_pos_nxt;
  logic        byte_sel_r, byte_sel_nxt;
  logic        permit_r, permit_nxt;

  word_t   tx_head;
  word_t   rx_head;
  result_t res;

  assign tx_head = tx_ring_r[ring_oldest(tx_wpos_r, tx_fill_r)];
  assign rx_head = rx_ring_r[ring_oldest(rx_wpos_r, rx_fill_r)];

  always_comb begin
    rx_wpos_nxt    = rx_wpos_r;
    rx_fill_nxt    = rx_fill_r;
    tx_wpos_nxt    = tx_wpos_r;
    tx_fill_nxt    = tx_fill_r;
    prefix_pos_nxt = prefix_pos_r;
    byte_sel_nxt   = byte_sel_r;
    permit_nxt     = permit_r;
    res            = '0;
    if (in_acc) begin
      unique case (in_item.command)
        CMD_RX_BYTE: begin
          if (evt.word_push) begin
            rx_wpos_nxt = ring_next(rx_wpos_r);
            if (rx_fill_r < FILL_W'(RING_DEPTH)) begin
              rx_fill_nxt = rx_fill_r + 1'b1;
            end
          end
          if (evt.permit_set) begin
            permit_nxt = 1'b1;
          end
        end
        CMD_TX_TICK: begin
          priority if (tx_fill_r == '0) begin
            res.tx_idle = 1'b1;
          end else if (prefix_pos_r < PREFIX_POS_W'(PREFIX_LEN)) begin
            res.tx_valid   = 1'b1;
            res.tx_byte    = PREFIX_TEXT[prefix_pos_r[PREFIX_IDX_W-1:0]];
            prefix_pos_nxt = prefix_pos_r + 1'b1;
          end else if (permit_r) begin
            // Low byte first; the word leaves the ring after its high byte.
            res.tx_valid = 1'b1;
            res.tx_byte  = byte_sel_r ? tx_head[15:8] : tx_head[7:0];
            byte_sel_nxt = !byte_sel_r;
            if (byte_sel_r) begin
              tx_fill_nxt    = tx_fill_r - 1'b1;
              permit_nxt     = 1'b0;
              prefix_pos_nxt = '0;
            end
          end
        end
        CMD_ENQUEUE: begin
          tx_wpos_nxt = ring_next(tx_wpos_r);
          if (tx_fill_r < FILL_W'(RING_DEPTH)) begin
            tx_fill_nxt = tx_fill_r + 1'b1;
          end
        end
        CMD_DEQUEUE: begin
          if (rx_fill_r != '0) begin
            res.rx_word       = rx_head;
            res.rx_word_valid = 1'b1;
            rx_fill_nxt       = rx_fill_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    res.rx_queued      = QUEUED_W'(rx_fill_nxt);
    res.tx_queued      = QUEUED_W'(tx_fill_nxt);
    res.send_permitted = permit_nxt;
  end

  always_ff @(posedge clk) begin
    if (evt.word_push) begin
      rx_ring_r[rx_wpos_r] <= evt.word;
    end
    if (in_acc && (in_item.command == CMD_ENQUEUE)) begin
      tx_ring_r[tx_wpos_r] <= in_item.send_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wpos_r    <= '0;
      rx_fill_r    <= '0;
      tx_wpos_r    <= '0;
      tx_fill_r    <= '0;
      prefix_pos_r <= '0;
      byte_sel_r   <= 1'b0;
      permit_r     <= 1'b0;
    end else begin
      rx_wpos_r    <= rx_wpos_nxt;
      rx_fill_r    <= rx_fill_nxt;
      tx_wpos_r    <= tx_wpos_nxt;
      tx_fill_r    <= tx_fill_nxt;
      prefix_pos_r <= prefix_pos_nxt;
      byte_sel_r   <= byte_sel_nxt;
      permit_r     <= permit_nxt;
    end
  end

  // Result buffer: the result register faces the port; the skid register
  // catches a result produced while the port is stalled.
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    out_vld_r, out_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  logic    out_pop;

  assign out_pop       = out_vld_r && out_item.ready;
  assign in_item.ready = !skid_vld_r;

  always_comb begin
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      if (out_pop) begin
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_vld_r || out_pop) begin
        out_nxt     = res;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = res;
        skid_vld_nxt = 1'b1;
      end
    end else if (out_pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  assign out_item.valid          = out_vld_r;
  assign out_item.tx_valid       = out_r.tx_valid;
  assign out_item.tx_byte        = out_r.tx_byte;
  assign out_item.tx_idle        = out_r.tx_idle;
  assign out_item.rx_word        = out_r.rx_word;
  assign out_item.rx_word_valid  = out_r.rx_word_valid;
  assign out_item.rx_queued      = out_r.rx_queued;
  assign out_item.tx_queued      = out_r.tx_queued;
  assign out_item.send_permitted = out_r.send_permitted;

  // The skid register is only ever filled behind a held result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held without a result in the output register");

  // Neither ring may report more words than it holds.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_fill_r <= FILL_W'(RING_DEPTH)) && (tx_fill_r <= FILL_W'(RING_DEPTH)))
    else $error("ring fill count beyond ring depth");

  // Halfway through a word the prefix is complete, the permit is held and the
  // word is still queued.
  a_word_half_sent: assert property (@(posedge clk) disable iff (!rst_n)
    byte_sel_r |-> (prefix_pos_r == PREFIX_POS_W'(PREFIX_LEN)) && permit_r
                   && (tx_fill_r != '0))
    else $error("word send in progress without prefix, permit or queued word");

  // Finishing a word restarts the prefix and withdraws the permit.
  a_word_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_item.command == CMD_TX_TICK) && byte_sel_r && (tx_fill_r != '0))
    |=> (prefix_pos_r == '0) && !permit_r && !byte_sel_r)
    else $error("prefix or permit not reset after a word was sent");

endmodule
